[hdl/ffpa_pkg.sv]
// Shared types, constants and codes for the first-fit partition allocator.
package ffpa_pkg;

	// Number of partitions that the scan visits, 1 to 8.
	localparam int NUM_BLOCKS = 8;
	// Number of size registers, fixed by the register map.
	localparam int NREGS      = 8;

	localparam int SIZE_W     = 16;
	localparam int ID_W       = 8;
	localparam int BIDX_W     = 3;
	localparam int CFG_IDX_W  = $clog2(NREGS);
	localparam int SCAN_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	// Partition capacities after reset.
	localparam logic [SIZE_W-1:0] SIZE_RESET [NREGS] = '{
		16'd100, 16'd200, 16'd300, 16'd400, 16'd500, 16'd0, 16'd0, 16'd0
	};

	// Request kinds.
	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_ALLOC    = 2'd0,
		ST_NOFIT    = 2'd1,
		ST_FREED    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

endpackage

[hdl/ffpa_if.sv]
// Request and result channel interfaces for the partition allocator.
interface ffpa_req_if;
	import ffpa_pkg::*;

	logic              valid;
	logic              ready;
	logic              func;
	logic [ID_W-1:0]   proc_id;
	logic [SIZE_W-1:0] req_size;

	modport source (output valid, func, proc_id, req_size, input ready);
	modport sink   (input valid, func, proc_id, req_size, output ready);
endinterface

interface ffpa_rsp_if;
	import ffpa_pkg::*;

	logic              valid;
	logic              ready;
	status_t           status;
	logic [BIDX_W-1:0] block_index;

	modport source (output valid, status, block_index, input ready);
	modport sink   (input valid, status, block_index, output ready);
endinterface

[hdl/ffpa_cfg_regs.sv]
// Partition size registers with a write port and one scan read port.
module ffpa_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ffpa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ffpa_pkg::SIZE_W-1:0]    cfg_data,
	input  logic [ffpa_pkg::BIDX_W-1:0]    rd_idx,
	output logic [ffpa_pkg::SIZE_W-1:0]    rd_size
);
	import ffpa_pkg::*;

	logic [SIZE_W-1:0] size_q [NREGS];

	// Load reset capacities, then take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREGS; i++) begin
				size_q[i] <= SIZE_RESET[i];
			end
		end else if (cfg_we) begin
			size_q[cfg_idx] <= cfg_data;
		end
	end

	// Select the capacity of the partition under scan
	assign rd_size = size_q[rd_idx[CFG_IDX_W-1:0]];

endmodule

[hdl/ffpa_engine.sv]
// Scan sequencer with one shared comparator, partition state and result register.
module ffpa_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	ffpa_req_if.sink                    req,
	ffpa_rsp_if.source                  rsp,
	output logic [ffpa_pkg::BIDX_W-1:0] size_idx,
	input  logic [ffpa_pkg::SIZE_W-1:0] size_rd
);
	import ffpa_pkg::*;

	typedef enum logic {S_IDLE, S_SCAN} state_t;

	state_t            state_q;
	logic [SCAN_W-1:0] idx_q;
	logic              func_q;
	logic [ID_W-1:0]   id_q;
	logic [SIZE_W-1:0] size_q;
	logic              busy_q  [NUM_BLOCKS];
	logic [ID_W-1:0]   owner_q [NUM_BLOCKS];
	logic              rsp_valid_q;
	status_t           status_q;
	logic [BIDX_W-1:0] bidx_q;

	logic hit;
	logic last;
	logic done;
	logic out_free;
	logic load;

	// Shared compare: capacity test on allocate, owner match on release
	always_comb begin
		if (func_q == FUNC_ALLOC) begin
			hit = !busy_q[idx_q] && (size_rd >= size_q);
		end else begin
			hit = busy_q[idx_q] && (owner_q[idx_q] == id_q);
		end
	end

	assign last     = (idx_q == SCAN_W'(NUM_BLOCKS - 1));
	assign done     = hit || last;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign load     = (state_q == S_SCAN) && done && out_free;

	assign size_idx  = BIDX_W'(idx_q);
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.block_index = bidx_q;

	// Sequence the scan, update busy flags and hold the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			func_q      <= FUNC_ALLOC;
			id_q        <= '0;
			size_q      <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= ST_ALLOC;
			bidx_q      <= '0;
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				busy_q[i] <= 1'b0;
			end
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						func_q  <= req.func;
						id_q    <= req.proc_id;
						size_q  <= req.req_size;
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (load) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (hit) begin
							busy_q[idx_q] <= (func_q == FUNC_ALLOC);
							bidx_q        <= BIDX_W'(idx_q);
							status_q      <= (func_q == FUNC_ALLOC) ? ST_ALLOC : ST_FREED;
						end else begin
							bidx_q   <= '0;
							status_q <= (func_q == FUNC_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
						end
					end else if (!done) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Record the owner of a newly claimed partition
	always_ff @(posedge clk) begin
		if (load && hit && (func_q == FUNC_ALLOC)) begin
			owner_q[idx_q] <= id_q;
		end
	end

endmodule

[hdl/first_fit_partition_allocator_top.sv]
// First-fit fixed-partition allocator: a request is accepted while the block is
// idle, then the partitions are visited one per cycle, lowest first, by a single
// shared comparator (capacity check on allocate, owner match on release). The
// scan stops at the first hit or after the last partition, and req.ready is low
// for the whole scan. The result sits in an output register, so a new request is
// taken while the previous result still waits, but a scan that finishes against a
// full output register holds until it drains. Partition sizes are written through
// cfg_we/cfg_idx/cfg_data and should only be changed while no request is in flight.
// Every partition is free after reset.
module first_fit_partition_allocator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	ffpa_req_if.sink                       req,
	ffpa_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [ffpa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ffpa_pkg::SIZE_W-1:0]    cfg_data
);
	import ffpa_pkg::*;

	logic [BIDX_W-1:0] size_idx;
	logic [SIZE_W-1:0] size_rd;

	ffpa_cfg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.rd_idx   (size_idx),
		.rd_size  (size_rd)
	);

	ffpa_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.size_idx (size_idx),
		.size_rd  (size_rd)
	);

endmodule

[hdl/ffpa_checker.sv]
// Port-level checks for the partition allocator, bound to the top level.
module ffpa_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_ready,
	input  logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  logic [1:0]                  rsp_status,
	input  logic [ffpa_pkg::BIDX_W-1:0] rsp_block_index
);
	import ffpa_pkg::*;

	// A waiting result beat holds its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_block_index))
		else $error("result beat changed while stalled");

	// Failures report partition zero
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_NOFIT || rsp_status == ST_NOTFOUND)
			|-> rsp_block_index == '0)
		else $error("failure result with nonzero partition");

	// Successful results name a partition that the scan covers
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_ALLOC || rsp_status == ST_FREED)
			|-> rsp_block_index <= BIDX_W'(NUM_BLOCKS - 1))
		else $error("result partition beyond the scanned range");

	// The scan occupies the block after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken during a scan");

endmodule

bind first_fit_partition_allocator_top ffpa_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_block_index (rsp.block_index)
);
